FILE: sv/assert_macros.svh
// Assertion helpers used by the parser unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, ignoring cycles in reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: sv/nnm_pkg.sv
package nnm_pkg;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_VT    = 8'd11;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CH_LOW_A = 8'd97;
	localparam logic [7:0] CH_LOW_B = 8'd98;
	localparam logic [7:0] CH_LOW_C = 8'd99;
	localparam logic [7:0] CH_LOW_D = 8'd100;
	localparam logic [7:0] CH_LOW_E = 8'd101;
	localparam logic [7:0] CH_LOW_F = 8'd102;
	localparam logic [7:0] CH_LOW_G = 8'd103;
	localparam logic [7:0] CH_LOW_H = 8'd104;

	// Field widths and limits
	localparam int NOTE_W     = 7;
	localparam int PITCH_W    = 4;
	localparam int OCT_MAG_W  = 5;
	localparam int INT_MAG_W  = 8;
	localparam logic [OCT_MAG_W-1:0] OCT_SAT = 5'd31;
	localparam logic [INT_MAG_W-1:0] INT_SAT = 8'd255;
	localparam logic signed [10:0] NOTE_MAX = 11'sd127;
	localparam logic signed [10:0] SEMIS_PER_OCT = 11'sd12;
	localparam logic signed [10:0] PITCH_BIAS = 11'sd2;
	localparam logic signed [6:0] OCT_DEFAULT = 7'sd4;

	typedef enum logic [2:0] {
		NP_LEAD   = 3'd0,
		NP_LETTER = 3'd1,
		NP_SHARP  = 3'd2,
		NP_FLAT   = 3'd3,
		NP_OCTPRE = 3'd4,
		NP_OCTWS  = 3'd5,
		NP_NUMBER = 3'd6,
		NP_TRAIL  = 3'd7
	} name_phase_t;

	typedef enum logic [1:0] {
		IP_LEAD   = 2'd0,
		IP_SIGN   = 2'd1,
		IP_DIGITS = 2'd2,
		IP_TRAIL  = 2'd3
	} int_phase_t;

	// Result of a finished string, from scanner to output register
	typedef struct packed {
		logic [NOTE_W-1:0] note_number;
		logic              status;
	} scan_result_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_CR;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// Letter to pitch offset (pitch + 2); bit 4 flags a valid letter
	function automatic logic [PITCH_W:0] letter_offset(input logic [7:0] c);
		logic [7:0] lc;
		logic [PITCH_W:0] r;
		lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
		case (lc)
			CH_LOW_C: r = {1'b1, 4'd2};
			CH_LOW_D: r = {1'b1, 4'd4};
			CH_LOW_E: r = {1'b1, 4'd6};
			CH_LOW_F: r = {1'b1, 4'd7};
			CH_LOW_G: r = {1'b1, 4'd9};
			CH_LOW_A: r = {1'b1, 4'd11};
			CH_LOW_B, CH_LOW_H: r = {1'b1, 4'd13};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/nnm_char_if.sv
interface nnm_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

FILE: sv/nnm_note_if.sv
interface nnm_note_if;
	logic                       valid;
	logic                       ready;
	logic [nnm_pkg::NOTE_W-1:0] note_number;
	logic                       status;

	modport source (output valid, output note_number, output status, input ready);
	modport sink (input valid, input note_number, input status, output ready);
endinterface

FILE: sv/nnm_scanner.sv
module nnm_scanner (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            char_code,
	output nnm_pkg::scan_result_t result
);

	nnm_pkg::name_phase_t             name_phase_q, name_phase_d;
	logic [nnm_pkg::PITCH_W-1:0]      pitch_q, pitch_d;
	logic                             oct_neg_q, oct_neg_d;
	logic [nnm_pkg::OCT_MAG_W-1:0]    oct_mag_q, oct_mag_d;
	logic                             oct_seen_q, oct_seen_d;
	logic                             name_fail_q, name_fail_d;
	nnm_pkg::int_phase_t              int_phase_q, int_phase_d;
	logic                             int_neg_q, int_neg_d;
	logic [nnm_pkg::INT_MAG_W-1:0]    int_mag_q, int_mag_d;
	logic                             int_fail_q, int_fail_d;

	logic                             blank, digit, ff, eos;
	logic [3:0]                       digit_val;
	logic [nnm_pkg::PITCH_W:0]        letter;
	logic [8:0]                       oct_acc;
	logic [11:0]                      int_acc;
	logic                             oct_pos, num_start, oct_digit;

	assign blank     = nnm_pkg::is_blank(char_code);
	assign digit     = nnm_pkg::is_digit(char_code);
	assign ff        = char_code == nnm_pkg::CH_FF;
	assign eos       = char_code == nnm_pkg::CH_NUL;
	assign digit_val = 4'(char_code - nnm_pkg::CH_ZERO);
	assign letter    = nnm_pkg::letter_offset(char_code);

	// Accumulate one decimal digit, times ten as shift and add
	assign oct_acc = {1'b0, oct_mag_q, 3'b0} + {3'b0, oct_mag_q, 1'b0} + {5'b0, digit_val};
	assign int_acc = {1'b0, int_mag_q, 3'b0} + {3'b0, int_mag_q, 1'b0} + {8'b0, digit_val};

	// Next state of the note name recogniser
	always_comb begin
		name_phase_d = name_phase_q;
		pitch_d      = pitch_q;
		oct_neg_d    = oct_neg_q;
		oct_mag_d    = oct_mag_q;
		oct_seen_d   = oct_seen_q;
		name_fail_d  = name_fail_q;
		oct_pos      = 1'b0;
		num_start    = 1'b0;
		oct_digit    = 1'b0;
		if (step && !eos && !name_fail_q) begin
			unique case (name_phase_q)
				nnm_pkg::NP_LEAD: begin
					if (!blank) begin
						if (letter[nnm_pkg::PITCH_W]) begin
							pitch_d      = letter[nnm_pkg::PITCH_W-1:0];
							name_phase_d = nnm_pkg::NP_LETTER;
						end else begin
							name_fail_d = 1'b1;
						end
					end
				end
				nnm_pkg::NP_LETTER: begin
					if (char_code == nnm_pkg::CH_HASH) begin
						pitch_d      = pitch_q + 4'd1;
						name_phase_d = nnm_pkg::NP_SHARP;
					end else if (char_code == nnm_pkg::CH_LOW_B) begin
						pitch_d      = pitch_q - 4'd1;
						name_phase_d = nnm_pkg::NP_FLAT;
					end else begin
						oct_pos = 1'b1;
					end
				end
				nnm_pkg::NP_SHARP: begin
					if (char_code == nnm_pkg::CH_HASH) begin
						pitch_d      = pitch_q + 4'd1;
						name_phase_d = nnm_pkg::NP_OCTPRE;
					end else begin
						oct_pos = 1'b1;
					end
				end
				nnm_pkg::NP_FLAT: begin
					if (char_code == nnm_pkg::CH_LOW_B) begin
						pitch_d      = pitch_q - 4'd1;
						name_phase_d = nnm_pkg::NP_OCTPRE;
					end else begin
						oct_pos = 1'b1;
					end
				end
				nnm_pkg::NP_OCTPRE: oct_pos = 1'b1;
				nnm_pkg::NP_OCTWS: num_start = !(blank || ff);
				nnm_pkg::NP_NUMBER: begin
					if (digit) begin
						oct_digit = 1'b1;
					end else if (blank && oct_seen_q) begin
						name_phase_d = nnm_pkg::NP_TRAIL;
					end else begin
						name_fail_d = 1'b1;
					end
				end
				nnm_pkg::NP_TRAIL: begin
					if (!blank) begin
						name_fail_d = 1'b1;
					end
				end
			endcase
		end
		// Octave position: blanks, form feed, or the number itself
		if (oct_pos) begin
			if (blank) begin
				name_phase_d = nnm_pkg::NP_OCTPRE;
			end else if (ff) begin
				name_phase_d = nnm_pkg::NP_OCTWS;
			end else begin
				num_start = 1'b1;
			end
		end
		if (num_start) begin
			if (char_code == nnm_pkg::CH_PLUS) begin
				name_phase_d = nnm_pkg::NP_NUMBER;
			end else if (char_code == nnm_pkg::CH_MINUS) begin
				oct_neg_d    = 1'b1;
				name_phase_d = nnm_pkg::NP_NUMBER;
			end else if (digit) begin
				oct_digit = 1'b1;
			end else begin
				name_fail_d = 1'b1;
			end
		end
		if (oct_digit) begin
			oct_mag_d    = (oct_acc > {4'b0, nnm_pkg::OCT_SAT}) ? nnm_pkg::OCT_SAT
					: oct_acc[nnm_pkg::OCT_MAG_W-1:0];
			oct_seen_d   = 1'b1;
			name_phase_d = nnm_pkg::NP_NUMBER;
		end
		// End of string: return to the idle state
		if (step && eos) begin
			name_phase_d = nnm_pkg::NP_LEAD;
			pitch_d      = '0;
			oct_neg_d    = 1'b0;
			oct_mag_d    = '0;
			oct_seen_d   = 1'b0;
			name_fail_d  = 1'b0;
		end
	end

	// Next state of the integer recogniser
	always_comb begin
		int_phase_d = int_phase_q;
		int_neg_d   = int_neg_q;
		int_mag_d   = int_mag_q;
		int_fail_d  = int_fail_q;
		if (step && eos) begin
			int_phase_d = nnm_pkg::IP_LEAD;
			int_neg_d   = 1'b0;
			int_mag_d   = '0;
			int_fail_d  = 1'b0;
		end else if (step && !int_fail_q) begin
			unique case (int_phase_q)
				nnm_pkg::IP_LEAD: begin
					if (blank || ff) begin
						int_phase_d = nnm_pkg::IP_LEAD;
					end else if (char_code == nnm_pkg::CH_PLUS) begin
						int_phase_d = nnm_pkg::IP_SIGN;
					end else if (char_code == nnm_pkg::CH_MINUS) begin
						int_neg_d   = 1'b1;
						int_phase_d = nnm_pkg::IP_SIGN;
					end else if (!digit) begin
						int_fail_d = 1'b1;
					end
				end
				nnm_pkg::IP_SIGN: int_fail_d = !digit;
				nnm_pkg::IP_DIGITS: begin
					if (blank) begin
						int_phase_d = nnm_pkg::IP_TRAIL;
					end else if (!digit) begin
						int_fail_d = 1'b1;
					end
				end
				nnm_pkg::IP_TRAIL: int_fail_d = !blank;
			endcase
			// Digits are taken in every phase but trailing blanks
			if (digit && int_phase_q != nnm_pkg::IP_TRAIL) begin
				int_mag_d   = (int_acc > {4'b0, nnm_pkg::INT_SAT}) ? nnm_pkg::INT_SAT
						: int_acc[nnm_pkg::INT_MAG_W-1:0];
				int_phase_d = nnm_pkg::IP_DIGITS;
			end
		end
	end

	// Hold the recogniser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_phase_q <= nnm_pkg::NP_LEAD;
			pitch_q      <= '0;
			oct_neg_q    <= 1'b0;
			oct_mag_q    <= '0;
			oct_seen_q   <= 1'b0;
			name_fail_q  <= 1'b0;
			int_phase_q  <= nnm_pkg::IP_LEAD;
			int_neg_q    <= 1'b0;
			int_mag_q    <= '0;
			int_fail_q   <= 1'b0;
		end else begin
			name_phase_q <= name_phase_d;
			pitch_q      <= pitch_d;
			oct_neg_q    <= oct_neg_d;
			oct_mag_q    <= oct_mag_d;
			oct_seen_q   <= oct_seen_d;
			name_fail_q  <= name_fail_d;
			int_phase_q  <= int_phase_d;
			int_neg_q    <= int_neg_d;
			int_mag_q    <= int_mag_d;
			int_fail_q   <= int_fail_d;
		end
	end

	// Result from the current state, used when the terminator arrives
	logic                name_ok, int_ok, ok;
	logic signed [6:0]   oct_v;
	logic signed [10:0]  name_v, int_v, value;

	always_comb begin
		name_ok = !name_fail_q && name_phase_q != nnm_pkg::NP_LEAD
				&& name_phase_q != nnm_pkg::NP_OCTWS
				&& !(name_phase_q == nnm_pkg::NP_NUMBER && !oct_seen_q);
		if (!oct_seen_q) begin
			oct_v = nnm_pkg::OCT_DEFAULT;
		end else if (oct_neg_q) begin
			oct_v = -$signed({2'b0, oct_mag_q});
		end else begin
			oct_v = $signed({2'b0, oct_mag_q});
		end
		name_v = (11'(oct_v) + 11'sd1) * nnm_pkg::SEMIS_PER_OCT
				+ $signed({7'b0, pitch_q}) - nnm_pkg::PITCH_BIAS;
		int_ok = !int_fail_q && (int_phase_q == nnm_pkg::IP_DIGITS
				|| int_phase_q == nnm_pkg::IP_TRAIL);
		int_v  = int_neg_q ? -$signed({3'b0, int_mag_q}) : $signed({3'b0, int_mag_q});
		value  = name_ok ? name_v : int_v;
		ok     = (name_ok || int_ok) && value >= 11'sd0 && value <= nnm_pkg::NOTE_MAX;
		result.note_number = ok ? value[nnm_pkg::NOTE_W-1:0] : '0;
		result.status      = !ok;
	end

endmodule

FILE: sv/note_name_to_midi_parser_unit.sv
// Note name to MIDI note parser. Feed a zero-terminated string one byte per
// transaction on chars; each zero byte produces one transaction on notes with
// the MIDI note number (status 0) or status 1 when the text is neither a valid
// note name such as "C#4", "bb-1" or "h" (octave 4 by default) nor a plain
// integer, or the value falls outside 0..127. One byte is taken every cycle:
// a byte waits in the input register while the recognisers update, and a
// terminator then places its result in the output register.
// Only a terminator meeting a full, stalled output register holds the input.
module note_name_to_midi_parser_unit (
	input  logic              clk,
	input  logic              arst_n,
	nnm_char_if.sink          chars,
	nnm_note_if.source        notes
);

	`include "assert_macros.svh"

	logic                        valid_s1;
	logic [7:0]                  char_s1;
	logic                        s1_end, s1_go;
	logic                        out_valid_q;
	logic [nnm_pkg::NOTE_W-1:0]  note_q;
	logic                        status_q;
	nnm_pkg::scan_result_t       result;

	// Advance the input stage unless a terminator meets a full, stalled output
	assign s1_end      = char_s1 == nnm_pkg::CH_NUL;
	assign s1_go       = valid_s1 && (!s1_end || !out_valid_q || notes.ready);
	assign chars.ready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
		end
	end

	nnm_scanner u_scanner (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_go),
		.char_code (char_s1),
		.result    (result)
	);

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_end) begin
			out_valid_q <= 1'b1;
		end else if (notes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_end) begin
			note_q   <= result.note_number;
			status_q <= result.status;
		end
	end

	assign notes.valid       = out_valid_q;
	assign notes.note_number = note_q;
	assign notes.status      = status_q;

	`ASSERT_CLK(a_invalid_zero, clk, arst_n, out_valid_q && status_q |-> note_q == '0, "invalid result with nonzero note")
	`ASSERT_CLK(a_end_holds, clk, arst_n, valid_s1 && s1_end && out_valid_q && !notes.ready |=> valid_s1 && s1_end, "terminator dropped while output stalled")
	`ASSERT_CLK(a_result_source, clk, arst_n, $rose(out_valid_q) |-> $past(valid_s1 && s1_end), "result without terminator")
	`ASSERT_ALWAYS(a_ready_free, clk, !chars.ready |-> valid_s1, "input stalled while stage empty")

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned CHAR_TARGET = 1550;
	localparam int unsigned CALM_FROM   = 1350;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		string                 text;
		bit                    fixed;
		nnm_pkg::scan_result_t outcome;
	} table_row_t;

	typedef struct {
		bit                    fixed;
		nnm_pkg::scan_result_t outcome;
	} string_tag_t;

	logic clk;
	logic arst_n;

	nnm_char_if chars_bus();
	nnm_note_if notes_bus();

	note_name_to_midi_parser_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_bus),
		.notes  (notes_bus)
	);

	// Note recogniser state
	nnm_pkg::name_phase_t note_phase;
	int                   note_pitch;
	bit                   oct_neg;
	int                   oct_mag;
	bit                   oct_seen;
	bit                   note_dead;

	// Integer recogniser state
	nnm_pkg::int_phase_t  num_phase;
	bit                   num_neg;
	int                   num_mag;
	bit                   num_dead;

	nnm_pkg::scan_result_t expected_notes[$];
	string_tag_t           string_tags[$];
	string_tag_t           seen_tag;
	nnm_pkg::scan_result_t predicted;
	nnm_pkg::scan_result_t wanted;

	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned sent_chars;
	int unsigned hold_left;
	int unsigned calm_left;
	bit          tail_calm;
	bit          gaps_on;

	// Short strings first: extremes, accidentals, form feed and sign corner cases
	table_row_t directed_rows [10] = '{
		'{"", 1'b1, {7'd0, 1'b1}},
		'{"\011C-1", 1'b1, {7'd0, 1'b0}},
		'{"G9", 1'b1, {7'd127, 1'b0}},
		'{"\013Hbb\0150 ", 1'b0, '0},
		'{"d##\014-0", 1'b0, '0},
		'{"a\014", 1'b1, {7'd0, 1'b1}},
		'{"\014-", 1'b1, {7'd0, 1'b1}},
		'{"999", 1'b1, {7'd0, 1'b1}},
		'{"\377", 1'b1, {7'd0, 1'b1}},
		'{"-0\012", 1'b0, '0}
	};

	task automatic flag_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	function automatic bit is_space_char(input logic [7:0] c);
		return c == nnm_pkg::CH_SPACE || c == nnm_pkg::CH_TAB || c == nnm_pkg::CH_LF
			|| c == nnm_pkg::CH_VT || c == nnm_pkg::CH_CR;
	endfunction

	function automatic bit is_decimal(input logic [7:0] c);
		return c >= nnm_pkg::CH_ZERO && c <= nnm_pkg::CH_NINE;
	endfunction

	// Semitone of a note letter, -1 when the byte is no letter
	function automatic int letter_semitone(input logic [7:0] c);
		logic [7:0] lc;
		lc = (c >= nnm_pkg::CH_UPPER_A && c <= nnm_pkg::CH_UPPER_Z) ? c + 8'd32 : c;
		case (lc)
			nnm_pkg::CH_LOW_C: return 0;
			nnm_pkg::CH_LOW_D: return 2;
			nnm_pkg::CH_LOW_E: return 4;
			nnm_pkg::CH_LOW_F: return 5;
			nnm_pkg::CH_LOW_G: return 7;
			nnm_pkg::CH_LOW_A: return 9;
			nnm_pkg::CH_LOW_B, nnm_pkg::CH_LOW_H: return 11;
			default: return -1;
		endcase
	endfunction

	function automatic void clear_scanners();
		note_phase = nnm_pkg::NP_LEAD;
		note_pitch = 0;
		oct_neg    = 1'b0;
		oct_mag    = 0;
		oct_seen   = 1'b0;
		note_dead  = 1'b0;
		num_phase  = nnm_pkg::IP_LEAD;
		num_neg    = 1'b0;
		num_mag    = 0;
		num_dead   = 1'b0;
	endfunction

	// Accumulate one octave digit, saturating
	function automatic void take_octave_digit(input logic [7:0] c);
		int m;
		m = oct_mag * 10 + int'(c - nnm_pkg::CH_ZERO);
		oct_mag    = (m > int'(nnm_pkg::OCT_SAT)) ? int'(nnm_pkg::OCT_SAT) : m;
		oct_seen   = 1'b1;
		note_phase = nnm_pkg::NP_NUMBER;
	endfunction

	function automatic void octave_start(input logic [7:0] c);
		if (c == nnm_pkg::CH_PLUS) begin
			note_phase = nnm_pkg::NP_NUMBER;
		end else if (c == nnm_pkg::CH_MINUS) begin
			oct_neg    = 1'b1;
			note_phase = nnm_pkg::NP_NUMBER;
		end else if (is_decimal(c)) begin
			take_octave_digit(c);
		end else begin
			note_dead = 1'b1;
		end
	endfunction

	function automatic void octave_slot(input logic [7:0] c);
		if (is_space_char(c))
			note_phase = nnm_pkg::NP_OCTPRE;
		else if (c == nnm_pkg::CH_FF)
			note_phase = nnm_pkg::NP_OCTWS;
		else
			octave_start(c);
	endfunction

	function automatic void scan_note(input logic [7:0] c);
		int p;
		if (note_dead)
			return;
		case (note_phase)
			nnm_pkg::NP_LEAD: begin
				if (!is_space_char(c)) begin
					p = letter_semitone(c);
					if (p < 0) begin
						note_dead = 1'b1;
					end else begin
						note_pitch = p;
						note_phase = nnm_pkg::NP_LETTER;
					end
				end
			end
			nnm_pkg::NP_LETTER: begin
				if (c == nnm_pkg::CH_HASH) begin
					note_pitch++;
					note_phase = nnm_pkg::NP_SHARP;
				end else if (c == nnm_pkg::CH_LOW_B) begin
					note_pitch--;
					note_phase = nnm_pkg::NP_FLAT;
				end else begin
					octave_slot(c);
				end
			end
			nnm_pkg::NP_SHARP: begin
				if (c == nnm_pkg::CH_HASH) begin
					note_pitch++;
					note_phase = nnm_pkg::NP_OCTPRE;
				end else begin
					octave_slot(c);
				end
			end
			nnm_pkg::NP_FLAT: begin
				if (c == nnm_pkg::CH_LOW_B) begin
					note_pitch--;
					note_phase = nnm_pkg::NP_OCTPRE;
				end else begin
					octave_slot(c);
				end
			end
			nnm_pkg::NP_OCTPRE: octave_slot(c);
			nnm_pkg::NP_OCTWS: begin
				if (!(is_space_char(c) || c == nnm_pkg::CH_FF))
					octave_start(c);
			end
			nnm_pkg::NP_NUMBER: begin
				if (is_decimal(c))
					take_octave_digit(c);
				else if (is_space_char(c) && oct_seen)
					note_phase = nnm_pkg::NP_TRAIL;
				else
					note_dead = 1'b1;
			end
			default: begin
				if (!is_space_char(c))
					note_dead = 1'b1;
			end
		endcase
	endfunction

	function automatic void scan_number(input logic [7:0] c);
		int m;
		if (num_dead)
			return;
		if ((num_phase == nnm_pkg::IP_LEAD && is_decimal(c))
				|| (num_phase == nnm_pkg::IP_SIGN && is_decimal(c))
				|| (num_phase == nnm_pkg::IP_DIGITS && is_decimal(c))) begin
			m = num_mag * 10 + int'(c - nnm_pkg::CH_ZERO);
			num_mag   = (m > int'(nnm_pkg::INT_SAT)) ? int'(nnm_pkg::INT_SAT) : m;
			num_phase = nnm_pkg::IP_DIGITS;
			return;
		end
		case (num_phase)
			nnm_pkg::IP_LEAD: begin
				if (c == nnm_pkg::CH_PLUS) begin
					num_phase = nnm_pkg::IP_SIGN;
				end else if (c == nnm_pkg::CH_MINUS) begin
					num_neg   = 1'b1;
					num_phase = nnm_pkg::IP_SIGN;
				end else if (!(is_space_char(c) || c == nnm_pkg::CH_FF)) begin
					num_dead = 1'b1;
				end
			end
			nnm_pkg::IP_SIGN: num_dead = 1'b1;
			nnm_pkg::IP_DIGITS: begin
				if (is_space_char(c))
					num_phase = nnm_pkg::IP_TRAIL;
				else
					num_dead = 1'b1;
			end
			default: begin
				if (!is_space_char(c))
					num_dead = 1'b1;
			end
		endcase
	endfunction

	// Close a string: note value first, integer as fallback, then range check
	function automatic nnm_pkg::scan_result_t finish_string();
		nnm_pkg::scan_result_t r;
		int v;
		bit ok;
		ok = 1'b0;
		v  = 0;
		if (!note_dead && note_phase != nnm_pkg::NP_LEAD && note_phase != nnm_pkg::NP_OCTWS &&
				!(note_phase == nnm_pkg::NP_NUMBER && !oct_seen)) begin
			ok = 1'b1;
			// default octave is 4, twelve semitones per octave
			v  = ((oct_seen ? (oct_neg ? -oct_mag : oct_mag) : 4) + 1) * 12 + note_pitch;
		end else if (!num_dead && (num_phase == nnm_pkg::IP_DIGITS
				|| num_phase == nnm_pkg::IP_TRAIL)) begin
			ok = 1'b1;
			v  = num_neg ? -num_mag : num_mag;
		end
		if (v < 0 || v > 127)
			ok = 1'b0;
		r.status      = !ok;
		r.note_number = ok ? v[6:0] : '0;
		clear_scanners();
		return r;
	endfunction

	function automatic logic [7:0] any_blank();
		case ($urandom_range(0, 4))
			0: return nnm_pkg::CH_SPACE;
			1: return nnm_pkg::CH_TAB;
			2: return nnm_pkg::CH_LF;
			3: return nnm_pkg::CH_VT;
			default: return nnm_pkg::CH_CR;
		endcase
	endfunction

	function automatic void push_decimal(ref byte_q_t q, input int unsigned value);
		string digits;
		digits = $sformatf("%0d", value);
		for (int k = 0; k < digits.len(); k++)
			q.push_back(digits[k]);
	endfunction

	function automatic void push_sign(ref byte_q_t q);
		case ($urandom_range(0, 7))
			0: q.push_back(nnm_pkg::CH_MINUS);
			1: q.push_back(nnm_pkg::CH_PLUS);
			default: ;
		endcase
	endfunction

	// Well-formed note name with random parts
	function automatic void compose_note(ref byte_q_t q);
		string letters;
		letters = "CDEFGABHcdefgabh";
		repeat ($urandom_range(0, 2)) q.push_back(any_blank());
		q.push_back(letters[$urandom_range(0, 15)]);
		case ($urandom_range(0, 5))
			1: q.push_back(nnm_pkg::CH_HASH);
			2: begin
				q.push_back(nnm_pkg::CH_HASH);
				q.push_back(nnm_pkg::CH_HASH);
			end
			3: q.push_back(nnm_pkg::CH_LOW_B);
			4: begin
				q.push_back(nnm_pkg::CH_LOW_B);
				q.push_back(nnm_pkg::CH_LOW_B);
			end
			default: ;
		endcase
		case ($urandom_range(0, 7))
			0: q.push_back(any_blank());
			1: q.push_back(nnm_pkg::CH_FF);
			2: begin
				q.push_back(any_blank());
				q.push_back(nnm_pkg::CH_FF);
			end
			default: ;
		endcase
		if ($urandom_range(0, 3) != 0) begin
			push_sign(q);
			push_decimal(q, ($urandom_range(0, 15) == 0) ? $urandom_range(10, 99999)
				: $urandom_range(0, 9));
		end
		repeat ($urandom_range(0, 2)) q.push_back(any_blank());
	endfunction

	// Well-formed signed integer with random parts
	function automatic void compose_integer(ref byte_q_t q);
		repeat ($urandom_range(0, 2))
			q.push_back(($urandom_range(0, 3) == 0) ? nnm_pkg::CH_FF : any_blank());
		push_sign(q);
		push_decimal(q, ($urandom_range(0, 9) == 0) ? $urandom_range(128, 99999)
			: $urandom_range(0, 130));
		repeat ($urandom_range(0, 2)) q.push_back(any_blank());
	endfunction

	function automatic void compose_text(ref byte_q_t q);
		int pick;
		int pos;
		q.delete();
		pick = $urandom_range(0, 19);
		if (pick < 9) begin
			compose_note(q);
		end else if (pick < 13) begin
			compose_integer(q);
		end else if (pick < 17) begin
			// break a well-formed text: overwrite, insert or cut one place
			if (pick < 16)
				compose_note(q);
			else
				compose_integer(q);
			pos = $urandom_range(0, q.size());
			case ($urandom_range(0, 2))
				0: q[pos % q.size()] = 8'($urandom_range(1, 255));
				1: q.insert(pos, 8'($urandom_range(1, 255)));
				default: while (q.size() > pos) void'(q.pop_back());
			endcase
		end else if (pick < 19) begin
			repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 3)) q.push_back(any_blank());
		end
	endfunction

	// Offer one byte from a falling edge and hold it until the transaction completes
	task automatic put_char(input logic [7:0] c);
		if (gaps_on && !tail_calm && $urandom_range(0, 4) == 0) begin
			chars_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		chars_bus.valid     <= 1'b1;
		chars_bus.char_code <= c;
		@(posedge clk);
		while (!chars_bus.ready) @(posedge clk);
		sent_chars++;
		@(negedge clk);
	endtask

	task automatic send_text(input byte_q_t q, input bit fixed,
			input nnm_pkg::scan_result_t outcome);
		string_tag_t tag;
		tag.fixed   = fixed;
		tag.outcome = outcome;
		string_tags.push_back(tag);
		gaps_on = ($urandom_range(0, 2) != 0);
		foreach (q[i]) put_char(q[i]);
		put_char(nnm_pkg::CH_NUL);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("note_name_to_midi_parser_unit regression: fail");
			$finish;
		end
	end

	// Predict on every accepted byte; a terminator queues one expected note
	always @(posedge clk) begin
		if (arst_n && chars_bus.valid && chars_bus.ready) begin
			if (chars_bus.char_code != nnm_pkg::CH_NUL) begin
				scan_note(chars_bus.char_code);
				scan_number(chars_bus.char_code);
			end else begin
				predicted = finish_string();
				if (string_tags.size() != 0) begin
					seen_tag = string_tags.pop_front();
					expected_notes.push_back(seen_tag.fixed ? seen_tag.outcome : predicted);
				end else begin
					expected_notes.push_back(predicted);
				end
			end
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && notes_bus.valid && notes_bus.ready) begin
			if (expected_notes.size() == 0) begin
				flag_mismatch($sformatf("unexpected result note %0d status %0d",
					notes_bus.note_number, notes_bus.status));
			end else begin
				wanted = expected_notes.pop_front();
				if (notes_bus.note_number !== wanted.note_number)
					flag_mismatch($sformatf("note_number %0d, expected %0d",
						notes_bus.note_number, wanted.note_number));
				if (notes_bus.status !== wanted.status)
					flag_mismatch($sformatf("status %0d, expected %0d",
						notes_bus.status, wanted.status));
			end
		end
	end

	// Stall the result side in bursts, with quiet stretches between them
	always @(negedge clk) begin
		if (!arst_n) begin
			notes_bus.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			notes_bus.ready <= 1'b0;
		end else if (calm_left > 0 || tail_calm) begin
			if (calm_left > 0)
				calm_left--;
			notes_bus.ready <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			hold_left = $urandom_range(0, 6);
			notes_bus.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				calm_left = $urandom_range(10, 60);
			notes_bus.ready <= 1'b1;
		end
	end

	initial begin
		byte_q_t text_bytes;
		string   label;
		mismatches          = 0;
		cycle_count         = 0;
		sent_chars          = 0;
		hold_left           = 0;
		calm_left           = 0;
		tail_calm           = 1'b0;
		gaps_on             = 1'b0;
		clear_scanners();
		arst_n              = 1'b0;
		chars_bus.valid     = 1'b0;
		chars_bus.char_code = nnm_pkg::CH_NUL;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (directed_rows[r]) begin
			text_bytes.delete();
			label = directed_rows[r].text;
			for (int k = 0; k < label.len(); k++)
				text_bytes.push_back(label[k]);
			send_text(text_bytes, directed_rows[r].fixed, directed_rows[r].outcome);
		end

		// Random strings, no idling towards the end
		while (sent_chars < CHAR_TARGET) begin
			if (sent_chars >= CALM_FROM)
				tail_calm = 1'b1;
			compose_text(text_bytes);
			send_text(text_bytes, 1'b0, '0);
		end
		chars_bus.valid <= 1'b0;

		// Drain outstanding notes, then watch for strays
		while (expected_notes.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("note_name_to_midi_parser_unit regression: pass");
		else
			$display("note_name_to_midi_parser_unit regression: fail");
		$finish;
	end

endmodule
